// ----- design/fnv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fnv_pkg;

	// FNV-1a 64-bit constants
	localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
	// prime = 2^40 + 0x1b3, so the multiply is a shift plus a small constant product
	localparam int unsigned PRIME_SHIFT = 40;
	localparam logic [8:0] PRIME_LOW = 9'h1b3;

	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;

	// Default length counter width
	localparam int unsigned LENGTH_BITS_DEF = 32;

	// Pending digests between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Number of words in one digest
	localparam int unsigned DIGEST_WORDS = 4;

	// Per-word mask constant: golden ratio times (k+1), mod 2^64
	localparam logic [63:0] GOLDEN_TERM [DIGEST_WORDS] = '{
		GOLDEN,
		64'(GOLDEN * 64'd2),
		64'(GOLDEN * 64'd3),
		64'(GOLDEN * 64'd4)
	};

	// Per-word length shift: 7k mod 24
	localparam logic [4:0] LEN_SHIFT [DIGEST_WORDS] = '{5'd0, 5'd7, 5'd14, 5'd21};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} msg_word_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  word_number;
		logic        final_word;
	} dig_word_t;

endpackage

`default_nettype wire

// ----- design/fnv_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fnv_queue import fnv_pkg::*; #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head,
	output logic                  empty
);

	localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full  = (count_q == CNT_BITS'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Store pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/fnv_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fnv_front import fnv_pkg::*; #(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      msg_valid,
	output logic                           msg_stall,
	input  wire msg_word_t                 msg,
	input  wire logic                      q_full,
	output logic                           q_push,
	output logic [64+LENGTH_BITS-1:0]      q_data
);

	logic [63:0]            hash_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic                   accept;
	logic [63:0]            mixed;
	logic [63:0]            hash_next;
	logic [LENGTH_BITS-1:0] len_next;

	// Hold the source while the digest queue is full
	assign msg_stall = q_full;
	assign accept    = msg_valid && !msg_stall;

	// Absorb one byte: xor, then multiply by 2^40 + 0x1b3 mod 2^64
	always_comb begin
		mixed     = hash_q ^ {56'd0, msg.data_byte};
		hash_next = hash_q;
		len_next  = len_q;
		if (msg.byte_valid) begin
			hash_next = (mixed << PRIME_SHIFT) + 64'(mixed * {55'd0, PRIME_LOW});
			if (len_q != '1) begin
				len_next = len_q + 1'b1;
			end
		end
	end

	// Hand finished message state to the back end
	assign q_push = accept && msg.end_of_message;
	assign q_data = {hash_next, len_next};

	// Update running state, re-arm after end of message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
			len_q  <= '0;
		end else if (accept) begin
			if (msg.end_of_message) begin
				hash_q <= FNV_BASIS;
				len_q  <= '0;
			end else begin
				hash_q <= hash_next;
				len_q  <= len_next;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/fnv_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fnv_back import fnv_pkg::*; #(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_empty,
	input  wire logic [64+LENGTH_BITS-1:0] q_head,
	output logic                           q_pop,
	output logic                           dig_valid,
	input  wire logic                      dig_stall,
	output dig_word_t                      dig
);

	logic                   dig_valid_q;
	dig_word_t              dig_q;
	logic [1:0]             word_q;
	logic                   advance;
	logic                   emit;
	logic [63:0]            head_hash;
	logic [LENGTH_BITS-1:0] head_len;
	logic [63:0]            len_term;
	dig_word_t              word_next;

	assign head_hash = q_head[64+LENGTH_BITS-1:LENGTH_BITS];
	assign head_len  = q_head[LENGTH_BITS-1:0];

	// Output register is free when empty or being taken
	assign advance = !dig_valid_q || !dig_stall;
	assign emit    = advance && !q_empty;
	assign q_pop   = emit && (word_q == 2'(DIGEST_WORDS - 1));

	// Build the current digest word from the queue head
	always_comb begin
		len_term              = 64'(head_len) << LEN_SHIFT[word_q];
		word_next.digest_word = head_hash ^ GOLDEN_TERM[word_q] ^ len_term;
		word_next.word_number = word_q;
		word_next.final_word  = (word_q == 2'(DIGEST_WORDS - 1));
	end

	// Load payload
	always_ff @(posedge clk) begin
		if (emit) begin
			dig_q <= word_next;
		end
	end

	// Advance word counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_valid_q <= 1'b0;
			word_q      <= '0;
		end else if (advance) begin
			dig_valid_q <= !q_empty;
			if (!q_empty) begin
				word_q <= word_q + 1'b1;
			end
		end
	end

	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;

endmodule

`default_nettype wire

// ----- design/fnv1a_64_digest_expander.sv -----
`timescale 1ns / 1ps
`default_nettype none

// FNV-1a 64-bit hash with a 32-byte digest. Takes one word per cycle while
// not stalled (one message byte, or a bare end marker) and updates the running
// hash in that same cycle with a single xor, shift and small constant product.
// On end of message the final hash and byte count go into a two-entry queue;
// the back end turns each queued entry into four 64-bit digest words, one per
// cycle while dig_stall is low, word 0 first. The input stalls only while two
// finished digests still wait in the queue. The length counter is LENGTH_BITS
// wide and saturates.
module fnv1a_64_digest_expander import fnv_pkg::*; #(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      msg_valid,
	output logic           msg_stall,
	input  wire msg_word_t msg,
	output logic           dig_valid,
	input  wire logic      dig_stall,
	output dig_word_t      dig
);

	localparam int unsigned ENTRY_BITS = 64 + LENGTH_BITS;

	logic                  q_push;
	logic [ENTRY_BITS-1:0] q_data;
	logic                  q_full;
	logic                  q_pop;
	logic [ENTRY_BITS-1:0] q_head;
	logic                  q_empty;

	fnv_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg      (msg),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_data)
	);

	fnv_queue #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_data),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	fnv_back #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.dig_valid(dig_valid),
		.dig_stall(dig_stall),
		.dig      (dig)
	);

`ifndef SYNTH
	// A finalized message is queued right after its end marker is taken
	a_final_queued: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_stall && msg.end_of_message |=> !q_empty)
		else $error("end of message accepted but digest queue empty");

	// Digest words of one message follow without a gap
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_stall && !dig.final_word |=> dig_valid)
		else $error("digest burst broken before final word");

	// Word numbers step by one within a digest
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_stall && !dig.final_word
		|=> dig.word_number == 2'($past(dig.word_number) + 2'd1))
		else $error("digest word out of order");

	// Each queue pop loads the final word of a digest
	a_pop_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> dig_valid && dig.final_word)
		else $error("queue popped without a final digest word");
`endif

endmodule

`default_nettype wire

// ----- test/tb_fnv1a_64_digest_expander.sv -----
`timescale 1ns / 1ps

module tb_fnv1a_64_digest_expander;
	import fnv_pkg::*;

	localparam int unsigned LEN_W = LENGTH_BITS_DEF;
	localparam int unsigned RANDOM_WORDS = 110;
	localparam int unsigned CALM_FIRST = 40;
	localparam int unsigned CALM_LAST = 75;
	localparam int unsigned IDLE_PCT = 28;
	localparam int unsigned TIMEOUT_CYCLES = 20_000;

	localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
	localparam logic [63:0] HASH_PRIME = 64'h00000100000001b3;
	localparam logic [63:0] PHI_MIX = 64'h9e3779b97f4a7c15;
	// Word 0 of an empty message: offset basis xor golden constant, length zero
	localparam logic [63:0] EMPTY_WORD0 = 64'h55c5e55dfb685f30;

	typedef struct packed {
		msg_word_t   w;
		bit          pinned;
		logic [63:0] word0;
	} vector_t;

	logic        clk;
	logic        arst_n;
	logic        msg_valid;
	logic        msg_stall;
	msg_word_t   msg;
	logic        dig_valid;
	logic        dig_stall;
	dig_word_t   dig;

	logic [63:0]      hash_model;
	logic [LEN_W-1:0] length_model;
	dig_word_t        pending_digest [$];
	int unsigned      mismatch_count;
	bit               calm;

	fnv1a_64_digest_expander #(
		.LENGTH_BITS(LEN_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg(msg),
		.dig_valid(dig_valid),
		.dig_stall(dig_stall),
		.dig(dig)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * TIMEOUT_CYCLES);
		$display("fnv1a_64_digest_expander verification failed");
		$finish;
	end

	// Hash one word and queue the four digest words when it ends a message
	task automatic absorb_word(input msg_word_t w, input bit pinned, input logic [63:0] word0);
		dig_word_t   d;
		logic [63:0] len_wide;
		int          k;
		if (w.byte_valid) begin
			hash_model = (hash_model ^ {56'd0, w.data_byte}) * HASH_PRIME;
			if (length_model != '1)
				length_model = length_model + 1'b1;
		end
		if (w.end_of_message) begin
			len_wide = 64'(length_model);
			for (k = 0; k < 4; k++) begin
				d.digest_word = hash_model ^ (PHI_MIX * 64'(k + 1))
					^ (len_wide << ((7 * k) % 24));
				if (k == 0 && pinned)
					d.digest_word = word0;
				d.word_number = 2'(k);
				d.final_word = (k == 3);
				pending_digest = {pending_digest, d};
			end
			hash_model = OFFSET_BASIS;
			length_model = '0;
		end
	endtask

	// Offer one word, idling at random first, and predict once it is taken
	task automatic send_word(input msg_word_t w, input bit pinned, input logic [63:0] word0);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg <= w;
		msg_valid <= 1'b1;
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
		absorb_word(w, pinned, word0);
	endtask

	// Hold off the sender until every queued digest word has come out
	task automatic drain_digests();
		msg_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_digest.size() != 0);
	endtask

	// Check each digest word against the oldest prediction; stall at random
	always @(posedge clk) begin
		dig_word_t exp_w;
		if (arst_n && dig_valid && !dig_stall) begin
			if (pending_digest.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected digest word, expected none, actual %h %0d %0b",
					$time, dig.digest_word, dig.word_number, dig.final_word);
			end else begin
				exp_w = pending_digest.pop_front();
				if (dig.digest_word !== exp_w.digest_word) begin
					mismatch_count++;
					$display("%0t: digest_word expected %h actual %h",
						$time, exp_w.digest_word, dig.digest_word);
				end
				if (dig.word_number !== exp_w.word_number) begin
					mismatch_count++;
					$display("%0t: word_number expected %0d actual %0d",
						$time, exp_w.word_number, dig.word_number);
				end
				if (dig.final_word !== exp_w.final_word) begin
					mismatch_count++;
					$display("%0t: final_word expected %0b actual %0b",
						$time, exp_w.final_word, dig.final_word);
				end
			end
		end
		dig_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
	end

	initial begin
		vector_t directed [19];
		msg_word_t   w;
		int unsigned r;
		int          i;

		// Directed: empty messages, idle words, field extremes, back-to-back ends
		directed = '{
			'{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_WORD0},
			'{'{8'h00, 1'b0, 1'b0}, 1'b0, 64'd0},
			'{'{8'hff, 1'b0, 1'b0}, 1'b0, 64'd0},
			'{'{8'hff, 1'b0, 1'b1}, 1'b1, EMPTY_WORD0},
			'{'{8'h00, 1'b1, 1'b1}, 1'b0, 64'd0},
			'{'{8'hff, 1'b1, 1'b1}, 1'b0, 64'd0},
			'{'{8'h61, 1'b1, 1'b0}, 1'b0, 64'd0},
			'{'{8'h00, 1'b0, 1'b0}, 1'b0, 64'd0},
			'{'{8'h62, 1'b1, 1'b0}, 1'b0, 64'd0},
			'{'{8'hff, 1'b0, 1'b1}, 1'b0, 64'd0},
			'{'{8'h80, 1'b1, 1'b0}, 1'b0, 64'd0},
			'{'{8'h01, 1'b1, 1'b0}, 1'b0, 64'd0},
			'{'{8'h7f, 1'b1, 1'b1}, 1'b0, 64'd0},
			'{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_WORD0},
			'{'{8'h55, 1'b1, 1'b1}, 1'b0, 64'd0},
			'{'{8'haa, 1'b1, 1'b1}, 1'b0, 64'd0},
			'{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_WORD0},
			'{'{8'h0f, 1'b1, 1'b1}, 1'b0, 64'd0},
			'{'{8'hf0, 1'b1, 1'b1}, 1'b0, 64'd0}
		};

		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		dig_stall = 1'b0;
		calm = 1'b0;
		mismatch_count = 0;
		hash_model = OFFSET_BASIS;
		length_model = '0;

		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 19; i++)
			send_word(directed[i].w, directed[i].pinned, directed[i].word0);
		drain_digests();

		// Random messages of short length, with idle words and bare end markers;
		// a stretch in the middle runs with no idling on either side
		for (i = 0; i < RANDOM_WORDS; i++) begin
			calm <= (i >= CALM_FIRST) && (i < CALM_LAST);
			r = $urandom_range(0, 99);
			w.data_byte = 8'($urandom);
			if (r < 8) begin
				w.byte_valid = 1'b0;
				w.end_of_message = 1'b0;
			end else if (r < 14) begin
				w.byte_valid = 1'b0;
				w.end_of_message = 1'b1;
			end else begin
				w.byte_valid = 1'b1;
				w.end_of_message = ($urandom_range(0, 5) == 0);
			end
			send_word(w, 1'b0, 64'd0);
		end
		calm <= 1'b0;

		// Let the last digests out, then idle before reporting the result
		drain_digests();
		repeat (20)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("fnv1a_64_digest_expander verification clean");
		else
			$display("fnv1a_64_digest_expander verification failed");
		$finish;
	end

endmodule
